@@ rtl/core/derb_pkg.sv @@
// ----------------------------------------------------------------------------
// derb_pkg
// Shared types and constants for the double-ended ring buffer.
// ----------------------------------------------------------------------------
package derb_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     was_empty;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // issue stage -> RMW stage
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              empty_pop;
  } issue_t;

endpackage

@@ rtl/core/derb_ram.sv @@
// ----------------------------------------------------------------------------
// derb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module derb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/derb_issue.sv @@
// ----------------------------------------------------------------------------
// derb_issue
// Front/back pointers and slot address selection at accept time.
// ----------------------------------------------------------------------------
module derb_issue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [1:0]               operation,
  input  logic [derb_pkg::OCC_W-1:0] count_cur,
  output derb_pkg::issue_t         issue
);

  localparam logic [derb_pkg::ADDR_W-1:0] LAST = derb_pkg::ADDR_W'(derb_pkg::DEPTH - 1);

  logic [derb_pkg::ADDR_W-1:0] front_ptr, back_ptr;
  logic [derb_pkg::ADDR_W-1:0] front_ptr_next, back_ptr_next;
  logic [derb_pkg::ADDR_W-1:0] front_up, front_dn, back_up, back_dn;
  logic                        empty;

  assign front_up = (front_ptr == LAST) ? '0 : front_ptr + 1'b1;
  assign front_dn = (front_ptr == '0) ? LAST : front_ptr - 1'b1;
  assign back_up  = (back_ptr == LAST) ? '0 : back_ptr + 1'b1;
  assign back_dn  = (back_ptr == '0) ? LAST : back_ptr - 1'b1;

  assign empty = (count_cur == '0);

  always_comb begin
    front_ptr_next  = front_ptr;
    back_ptr_next   = back_ptr;
    issue.addr      = '0;
    issue.empty_pop = 1'b0;
    case (operation)
      derb_pkg::OP_PUSH_FRONT: begin
        issue.addr     = front_ptr;
        front_ptr_next = front_up;
      end
      derb_pkg::OP_PUSH_BACK: begin
        issue.addr    = back_ptr;
        back_ptr_next = back_dn;
      end
      derb_pkg::OP_POP_FRONT: begin
        if (empty) begin
          issue.empty_pop = 1'b1;
        end else begin
          issue.addr     = front_dn;
          front_ptr_next = front_dn;
        end
      end
      derb_pkg::OP_POP_BACK: begin
        if (empty) begin
          issue.empty_pop = 1'b1;
        end else begin
          issue.addr    = back_up;
          back_ptr_next = back_up;
        end
      end
      default: begin
        issue.addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      back_ptr  <= LAST;
    end else if (fire) begin
      front_ptr <= front_ptr_next;
      back_ptr  <= back_ptr_next;
    end
  end

endmodule

@@ rtl/core/double_ended_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// double_ended_ring_buffer
// Deque of signed words in a ring of RAM slots, pushed and popped at
// both ends; a zero word marks a free slot.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------
//  request   | start && !busy      | operation, data_in
//  result    | done (1-cycle pulse)| data_out, was_empty, occupancy
//
//  One item per cycle sustained once clearing is over. An item is accepted
//  (pointer update and slot read), read-modify-written in the RMW stage,
//  and its result is registered and pulses on done.
//  A back-to-back hit on the slot being written is served by a bypass
//  register, and the occupancy count is forwarded from the RMW stage into
//  the empty check of the next item.
//  After reset the slot RAM is cleared one slot per cycle: busy stays high
//  until all DEPTH slots are zeroed, and no item is taken before then.
//  The receiver cannot stall; busy is high only during the clearing pass.
// ----------------------------------------------------------------------------
module double_ended_ring_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  derb_pkg::in_item_t  request,
  output logic                done,
  output derb_pkg::out_item_t result
);

  localparam int DW = derb_pkg::DATA_W;
  localparam int AW = derb_pkg::ADDR_W;
  localparam int OW = derb_pkg::OCC_W;
  localparam logic [AW-1:0] LAST = AW'(derb_pkg::DEPTH - 1);
  localparam logic [OW-1:0] FULL = OW'(derb_pkg::DEPTH);

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // occupancy
  logic [OW-1:0] count, count_next, count_cur;

  // accept / issue
  logic             fire;
  derb_pkg::issue_t issue;

  // RMW stage
  logic                   s1_valid;
  logic [1:0]             s1_op;
  logic signed [DW-1:0]   s1_data;
  logic [AW-1:0]          s1_addr;
  logic                   s1_empty;
  logic                   s1_fwd;
  logic [DW-1:0]          s1_fwd_data;
  logic [DW-1:0]          rd_data;
  logic [DW-1:0]          old_word;
  logic                   s1_we;
  logic [DW-1:0]          s1_wdata;
  logic                   is_push;

  // RAM write port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;

  assign busy = clearing;
  assign fire = start && !clearing;

  // count seen by the item being accepted includes the one in the RMW stage
  assign count_cur = s1_valid ? count_next : count;

  derb_issue u_issue (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .operation (request.operation),
    .count_cur (count_cur),
    .issue     (issue)
  );

  derb_ram #(
    .WIDTH (DW),
    .DEPTH (derb_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue.addr),
    .rdata (rd_data)
  );

  // ---- RMW stage ----
  assign old_word = s1_fwd ? s1_fwd_data : rd_data;
  assign is_push  = !s1_op[1];
  assign s1_we    = s1_valid && !s1_empty;
  assign s1_wdata = is_push ? s1_data : '0;

  always_comb begin
    count_next = count;
    if (s1_empty) begin
      count_next = count;
    end else if (is_push) begin
      if ((old_word == '0) && (count != FULL)) begin
        count_next = count + 1'b1;
      end
    end else begin
      count_next = count - 1'b1;
    end
  end

  assign ram_we    = clearing || s1_we;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : s1_wdata;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= fire;
      if (s1_valid) begin
        count <= count_next;
      end
      done <= s1_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_op       <= request.operation;
      s1_data     <= request.data_in;
      s1_addr     <= issue.addr;
      s1_empty    <= issue.empty_pop;
      // same slot written this cycle: RAM read returns stale data
      s1_fwd      <= s1_we && (s1_addr == issue.addr);
      s1_fwd_data <= s1_wdata;
    end
    if (s1_valid) begin
      result.data_out  <= is_push ? '0 : old_word;
      result.was_empty <= s1_empty;
      result.occupancy <= count_next;
    end
  end

endmodule
